### rtl/slks_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slks_pkg: shared definitions for the serial line keyword spotter
// Keyword texts, number parser phases, result record and line size default.
// ----------------------------------------------------------------------------
package slks_pkg;

  localparam int unsigned LINE_CAPACITY_DEF = 200;

  localparam int unsigned KEY_COUNT   = 6;
  localparam int unsigned KW_MAX_LEN  = 14;
  localparam int unsigned KEY_SUB     = 0;
  localparam int unsigned KEY_ATTACH  = 1;
  localparam int unsigned KEY_OPEN    = 2;
  localparam int unsigned KEY_CLOSE   = 3;
  localparam int unsigned KEY_HALT    = 4;
  localparam int unsigned KEY_LEVEL   = 5;

  typedef logic [KW_MAX_LEN-1:0][7:0] kw_text_t;

  // Character j of a keyword sits in element KW_MAX_LEN-1-j; short keywords
  // are padded with NUL bytes, which never take part in matching.
  localparam kw_text_t KW_TEXT [KEY_COUNT] = '{
    {"QMTSUB: 0,1,0", 8'h00},
    {"CGATT: 1", 48'h0},
    {"\"temp\":\"open\"", 8'h00},
    {"\"temp\":\"close\""},
    {"\"temp\":\"halt\"", 8'h00},
    {"\"level\":", 48'h0}
  };

  localparam int unsigned KW_LEN [KEY_COUNT] = '{13, 8, 13, 14, 13, 8};

  localparam logic [7:0] CHAR_NUL     = 8'd0;
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_TAB     = 8'd9;
  localparam logic [7:0] CHAR_CR      = 8'd13;
  localparam logic [7:0] CHAR_SPACE   = 8'd32;
  localparam logic [7:0] CHAR_PLUS    = 8'd43;
  localparam logic [7:0] CHAR_MINUS   = 8'd45;
  localparam logic [7:0] CHAR_ZERO    = 8'd48;
  localparam logic [7:0] CHAR_NINE    = 8'd57;

  localparam logic [6:0] LEVEL_MAX       = 7'd100;
  localparam logic [6:0] LEVEL_SAT       = 7'd101;
  localparam logic [6:0] THRESHOLD_RESET = 7'd50;

  localparam logic [1:0] LID_NONE  = 2'd0;
  localparam logic [1:0] LID_OPEN  = 2'd1;
  localparam logic [1:0] LID_CLOSE = 2'd2;
  localparam logic [1:0] LID_HALT  = 2'd3;

  typedef enum logic [3:0] {
    PH_WAIT   = 4'b0001,
    PH_SKIP   = 4'b0010,
    PH_DIGITS = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic       subscribe_ack;
    logic       attach_ok;
    logic [1:0] lid_command;
    logic       level_seen;
    logic       level_accepted;
    logic [6:0] threshold;
  } result_t;

endpackage
`default_nettype wire

### rtl/serial_line_keyword_spotter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// serial_line_keyword_spotter_core: keyword spotter for a received byte line
// Scans each text line for six fixed keywords and a decimal level value.
// ----------------------------------------------------------------------------
// The block takes one received byte per request and may take a new byte in
// every clock cycle: all per-byte work (keyword matching, number parsing and
// the end-of-line decision) is one level of shallow logic from the input port
// into the line state registers and the result register. A new result goes
// to the output register, or to the skid register behind an older result.
// With the output register and one skid register, bytes keep flowing while a
// result waits; input ready drops only when both hold undelivered results.
// Keywords are matched as substrings with a shift-and bit vector per keyword,
// which tracks every matched prefix at once. After the level key the text is
// read as an atoi-style number (white space, optional sign, digits) that
// saturates at 101. A level of 0 to 100 at newline replaces the threshold
// (50 after reset). A NUL byte freezes the rest of the line, a full line is
// cleared with the byte dropped, and a clear_line request discards the
// partial line without a result.
// ----------------------------------------------------------------------------
module serial_line_keyword_spotter_core #(
  parameter int unsigned LINE_CAPACITY = slks_pkg::LINE_CAPACITY_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       in_clear_line,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_subscribe_ack,
  output logic            out_attach_ok,
  output logic [1:0]      out_lid_command,
  output logic            out_level_seen,
  output logic            out_level_accepted,
  output logic [6:0]      out_threshold
);

  localparam int unsigned FILL_W = $clog2(LINE_CAPACITY);
  localparam int unsigned KC = slks_pkg::KEY_COUNT;
  localparam int unsigned KL = slks_pkg::KW_MAX_LEN;

  // Line state.
  logic [KL-1:0]      match_r [KC];
  logic [KL-1:0]      match_nxt [KC];
  logic [KC-1:0]      found_r, found_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  slks_pkg::phase_t   phase_r, phase_nxt;
  logic [6:0]         value_r, value_nxt;
  logic               neg_r, neg_nxt;
  logic               frozen_r, frozen_nxt;
  logic [6:0]         thr_r, thr_nxt;

  // Result side: output register and skid register.
  slks_pkg::result_t  out_r, out_nxt, skid_r, skid_nxt;
  logic               out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;

  slks_pkg::result_t  res;
  logic               res_valid;
  logic               in_fire, out_free;
  logic               is_digit, is_space;
  logic [10:0]        acc;
  logic [KL-1:0]      eq;

  assign in_ready = !skid_valid_r;
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign is_digit = (in_rx_byte >= slks_pkg::CHAR_ZERO) && (in_rx_byte <= slks_pkg::CHAR_NINE);
  assign is_space = (in_rx_byte == slks_pkg::CHAR_SPACE) ||
                    ((in_rx_byte >= slks_pkg::CHAR_TAB) && (in_rx_byte <= slks_pkg::CHAR_CR));
  assign acc = 11'(value_r) * 11'd10 + 11'(in_rx_byte[3:0]);

  always_comb begin
    match_nxt  = match_r;
    found_nxt  = found_r;
    fill_nxt   = fill_r;
    phase_nxt  = phase_r;
    value_nxt  = value_r;
    neg_nxt    = neg_r;
    frozen_nxt = frozen_r;
    thr_nxt    = thr_r;
    res_valid  = 1'b0;
    res        = '0;
    eq         = '0;

    if (in_fire) begin
      if (in_clear_line) begin
        for (int i = 0; i < KC; i++) match_nxt[i] = '0;
        found_nxt  = '0;
        fill_nxt   = '0;
        phase_nxt  = slks_pkg::PH_WAIT;
        value_nxt  = '0;
        neg_nxt    = 1'b0;
        frozen_nxt = 1'b0;
      end else begin
        if (fill_r < FILL_W'(LINE_CAPACITY - 1)) begin
          fill_nxt   = fill_r + FILL_W'(1);
          frozen_nxt = frozen_r || (in_rx_byte == slks_pkg::CHAR_NUL);
          if (!frozen_nxt) begin
            // Number parser, run before the keyword update so that the byte
            // that completes the level key is not itself parsed.
            case (phase_r)
              slks_pkg::PH_SKIP: begin
                if (is_space) begin
                  phase_nxt = slks_pkg::PH_SKIP;
                end else if (in_rx_byte == slks_pkg::CHAR_PLUS ||
                             in_rx_byte == slks_pkg::CHAR_MINUS) begin
                  neg_nxt   = (in_rx_byte == slks_pkg::CHAR_MINUS);
                  phase_nxt = slks_pkg::PH_DIGITS;
                end else if (!is_digit) begin
                  phase_nxt = slks_pkg::PH_DONE;
                end else begin
                  phase_nxt = slks_pkg::PH_DIGITS;
                  value_nxt = (acc > 11'(slks_pkg::LEVEL_MAX)) ? slks_pkg::LEVEL_SAT : acc[6:0];
                end
              end
              slks_pkg::PH_DIGITS: begin
                if (!is_digit) begin
                  phase_nxt = slks_pkg::PH_DONE;
                end else begin
                  value_nxt = (acc > 11'(slks_pkg::LEVEL_MAX)) ? slks_pkg::LEVEL_SAT : acc[6:0];
                end
              end
              default: begin
                phase_nxt = phase_r;
              end
            endcase

            // Shift-and matcher: bit j set means the first j+1 characters of
            // the keyword end at the current byte.
            for (int i = 0; i < KC; i++) begin
              if (!found_r[i]) begin
                for (int j = 0; j < KL; j++) begin
                  eq[j] = (in_rx_byte == slks_pkg::KW_TEXT[i][KL-1-j]);
                end
                match_nxt[i] = {match_r[i][KL-2:0], 1'b1} & eq;
                found_nxt[i] = match_nxt[i][slks_pkg::KW_LEN[i]-1];
                if (i == slks_pkg::KEY_LEVEL && found_nxt[i] &&
                    phase_nxt == slks_pkg::PH_WAIT) begin
                  phase_nxt = slks_pkg::PH_SKIP;
                end
              end
            end
          end
        end else begin
          // Line full: drop the byte and start over.
          for (int i = 0; i < KC; i++) match_nxt[i] = '0;
          found_nxt  = '0;
          fill_nxt   = '0;
          phase_nxt  = slks_pkg::PH_WAIT;
          value_nxt  = '0;
          neg_nxt    = 1'b0;
          frozen_nxt = 1'b0;
        end

        if (in_rx_byte == slks_pkg::CHAR_NEWLINE) begin
          res_valid         = 1'b1;
          res.subscribe_ack = found_nxt[slks_pkg::KEY_SUB];
          res.attach_ok     = found_nxt[slks_pkg::KEY_ATTACH];
          if (found_nxt[slks_pkg::KEY_OPEN]) begin
            res.lid_command = slks_pkg::LID_OPEN;
          end else if (found_nxt[slks_pkg::KEY_CLOSE]) begin
            res.lid_command = slks_pkg::LID_CLOSE;
          end else if (found_nxt[slks_pkg::KEY_HALT]) begin
            res.lid_command = slks_pkg::LID_HALT;
          end else begin
            res.lid_command = slks_pkg::LID_NONE;
          end
          res.level_seen = (phase_nxt != slks_pkg::PH_WAIT);
          // A negative sign is only tolerated on a zero magnitude.
          if (res.level_seen && (value_nxt <= slks_pkg::LEVEL_MAX) &&
              !(neg_nxt && value_nxt != 7'd0)) begin
            thr_nxt            = value_nxt;
            res.level_accepted = 1'b1;
          end
          res.threshold = thr_nxt;

          for (int i = 0; i < KC; i++) match_nxt[i] = '0;
          found_nxt  = '0;
          fill_nxt   = '0;
          phase_nxt  = slks_pkg::PH_WAIT;
          value_nxt  = '0;
          neg_nxt    = 1'b0;
          frozen_nxt = 1'b0;
        end
      end
    end
  end

  // Result ordering: the skid entry is always older than a new result.
  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_nxt       = res;
        skid_valid_nxt = res_valid;
      end else begin
        out_nxt       = res;
        out_valid_nxt = res_valid;
      end
    end else if (res_valid) begin
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KC; i++) match_r[i] <= '0;
      found_r      <= '0;
      fill_r       <= '0;
      phase_r      <= slks_pkg::PH_WAIT;
      value_r      <= '0;
      neg_r        <= 1'b0;
      frozen_r     <= 1'b0;
      thr_r        <= slks_pkg::THRESHOLD_RESET;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      match_r      <= match_nxt;
      found_r      <= found_nxt;
      fill_r       <= fill_nxt;
      phase_r      <= phase_nxt;
      value_r      <= value_nxt;
      neg_r        <= neg_nxt;
      frozen_r     <= frozen_nxt;
      thr_r        <= thr_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_subscribe_ack  = out_r.subscribe_ack;
  assign out_attach_ok      = out_r.attach_ok;
  assign out_lid_command    = out_r.lid_command;
  assign out_level_seen     = out_r.level_seen;
  assign out_level_accepted = out_r.level_accepted;
  assign out_threshold      = out_r.threshold;

endmodule
`default_nettype wire
